[design/lfbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame builder/checker package
// Shared widths, codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package lfbc_pkg;

  localparam int unsigned ACTION_W      = 3;
  localparam int unsigned ID_W          = 6;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned DEF_MAX_PAYLOAD = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TX_START = 3'd0,
    ACT_TX_DATA  = 3'd1,
    ACT_RX_START = 3'd2,
    ACT_RX_BYTE  = 3'd3,
    ACT_RX_END   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TX   = 2'd1,
    PH_RX   = 2'd2
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX_BYTE  = 2'd0,
    KIND_RX_DATA  = 2'd1,
    KIND_RX_STAT  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SEL_SYNC,
    SEL_PID,
    SEL_DATA,
    SEL_CSUM,
    SEL_RX_BYTE,
    SEL_ERR_CSUM,
    SEL_ERR_TIMEOUT
  } out_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HDR_SYNC,
    S_HDR_PID,
    S_TX_ECHO,
    S_TX_ECHO_LAST,
    S_TX_CSUM,
    S_ERR_CSUM,
    S_ERR_TIMEOUT,
    S_FETCH,
    S_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic     latch;
    logic     upd_start;
    logic     upd_tx;
    logic     rx_store;
    logic     set_idle;
    logic     idx_clr;
    logic     idx_inc;
    logic     load_out;
    logic     out_last;
    out_sel_t out_sel;
  } lfbc_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    phase_t              phase;
    logic                tx_done;
    logic                rx_full;
    logic                csum_match;
    logic                out_free;
    logic                idx_last;
  } lfbc_sts_t;

  // Protected identifier: P0 in bit 6, inverted P1 in bit 7.
  function automatic logic [BYTE_W-1:0] make_pid(input logic [ID_W-1:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

[design/lfbc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame builder/checker input channel
// Valid/ready channel carrying one action item.
// ----------------------------------------------------------------------------
interface lfbc_in_if;
  import lfbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     frame_number;
  logic                enhanced_mode;
  logic [LEN_W-1:0]    payload_length;
  logic [BYTE_W-1:0]   data_value;

  modport source (
    output valid, action, frame_number, enhanced_mode, payload_length, data_value,
    input  ready
  );

  modport sink (
    input  valid, action, frame_number, enhanced_mode, payload_length, data_value,
    output ready
  );

endinterface

[design/lfbc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame builder/checker result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface lfbc_out_if;
  import lfbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   byte_value;
  logic [STATUS_W-1:0] status;
  logic                last_flag;

  modport source (
    output valid, out_kind, byte_value, status, last_flag,
    input  ready
  );

  modport sink (
    input  valid, out_kind, byte_value, status, last_flag,
    output ready
  );

endinterface

[design/lfbc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/lfbc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame builder/checker datapath
// Item latch, frame counters, checksum accumulator, receive buffer and the
// result register.
// ----------------------------------------------------------------------------
module lfbc_dp #(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfbc_pkg::lfbc_cmd_t           cmd,
  output lfbc_pkg::lfbc_sts_t           sts,
  input  logic [lfbc_pkg::ACTION_W-1:0] in_action,
  input  logic [lfbc_pkg::ID_W-1:0]     in_frame_number,
  input  logic                          in_enhanced_mode,
  input  logic [lfbc_pkg::LEN_W-1:0]    in_payload_length,
  input  logic [lfbc_pkg::BYTE_W-1:0]   in_data_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfbc_pkg::KIND_W-1:0]   out_kind,
  output logic [lfbc_pkg::BYTE_W-1:0]   out_byte_value,
  output logic [lfbc_pkg::STATUS_W-1:0] out_status,
  output logic                          out_last_flag
);
  import lfbc_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // latched item
  logic [ACTION_W-1:0] act_r;
  logic [ID_W-1:0]     id_r;
  logic                enh_r;
  logic [LEN_W-1:0]    len_r;
  logic [BYTE_W-1:0]   data_r;

  // frame state
  phase_t              phase_r, phase_nxt;
  logic [LEN_W-1:0]    exp_r, exp_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  logic                last_r, last_nxt;

  logic [BYTE_W-1:0]   pid;
  logic [BYTE_W-1:0]   sum_added;
  logic [LEN_W-1:0]    len_clamped;
  logic [LEN_W-1:0]    cnt_inc;
  logic [BYTE_W-1:0]   rd_data;
  logic                out_free;

  // 8-bit add with end-around carry
  function automatic logic [BYTE_W-1:0] sum_add(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W] ? (s[BYTE_W-1:0] + 8'd1) : s[BYTE_W-1:0];
  endfunction

  assign pid       = make_pid(id_r);
  assign sum_added = sum_add(sum_r, data_r);
  assign cnt_inc   = cnt_r + 4'd1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    priority if (len_r == '0) begin
      len_clamped = 4'd1;
    end else if (len_r > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = len_r;
    end
  end

  lfbc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_rx_buf (
    .clk   (clk),
    .we    (cmd.rx_store),
    .waddr (cnt_r[AW-1:0]),
    .wdata (data_r),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      id_r   <= in_frame_number;
      enh_r  <= in_enhanced_mode;
      len_r  <= in_payload_length;
      data_r <= in_data_value;
    end
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      exp_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      exp_r       <= exp_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame state update
  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    if (cmd.upd_start) begin
      phase_nxt = (act_r == ACT_TX_START) ? PH_TX : PH_RX;
      exp_nxt   = len_clamped;
      cnt_nxt   = '0;
      sum_nxt   = enh_r ? pid : '0;
    end
    if (cmd.upd_tx || cmd.rx_store) begin
      sum_nxt = sum_added;
      cnt_nxt = cnt_inc;
    end
    if ((cmd.upd_tx && sts.tx_done) || cmd.set_idle) begin
      phase_nxt = PH_IDLE;
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    stat_nxt      = stat_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      last_nxt      = cmd.out_last;
      kind_nxt      = KIND_TX_BYTE;
      stat_nxt      = ST_OK;
      byte_nxt      = '0;
      unique case (cmd.out_sel)
        SEL_SYNC:        byte_nxt = SYNC_BYTE;
        SEL_PID:         byte_nxt = pid;
        SEL_DATA:        byte_nxt = data_r;
        SEL_CSUM:        byte_nxt = ~sum_r;
        SEL_RX_BYTE: begin
          kind_nxt = KIND_RX_DATA;
          byte_nxt = rd_data;
        end
        SEL_ERR_CSUM: begin
          kind_nxt = KIND_RX_STAT;
          stat_nxt = ST_CSUM_ERR;
        end
        SEL_ERR_TIMEOUT: begin
          kind_nxt = KIND_RX_STAT;
          stat_nxt = ST_TIMEOUT;
        end
        default: begin
          kind_nxt = KIND_TX_BYTE;
        end
      endcase
    end
  end

  always_comb begin
    sts.action     = act_r;
    sts.phase      = phase_r;
    sts.tx_done    = (cnt_inc >= exp_r);
    sts.rx_full    = (cnt_r >= exp_r) || (cnt_r >= MAX_LEN);
    sts.csum_match = (~sum_r == data_r);
    sts.out_free   = out_free;
    sts.idx_last   = ((LEN_W'(idx_r) + 4'd1) == cnt_r);
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_byte_value = byte_r;
  assign out_status     = stat_r;
  assign out_last_flag  = last_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result register overwritten while occupied");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rx_store |-> (cnt_r < exp_r) && (cnt_r < MAX_LEN))
    else $error("receive buffer written beyond frame length");

  a_drain_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.out_sel == SEL_RX_BYTE) |-> phase_r == PH_IDLE)
    else $error("receive data released while frame still open");

  a_open_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (exp_r != '0) && (exp_r <= MAX_LEN))
    else $error("open frame with length out of range");
`endif

endmodule

[design/lfbc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame builder/checker controller
// Decodes each accepted item against the frame phase and sequences the
// result words it causes.
// ----------------------------------------------------------------------------
module lfbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfbc_pkg::lfbc_sts_t sts,
  output lfbc_pkg::lfbc_cmd_t cmd
);
  import lfbc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.action == ACT_TX_START || sts.action == ACT_RX_START) begin
          cmd.upd_start = 1'b1;
          state_nxt     = S_HDR_SYNC;
        end else if (sts.action == ACT_TX_DATA && sts.phase == PH_TX) begin
          cmd.upd_tx = 1'b1;
          state_nxt  = sts.tx_done ? S_TX_ECHO_LAST : S_TX_ECHO;
        end else if (sts.action == ACT_RX_BYTE && sts.phase == PH_RX) begin
          if (!sts.rx_full) begin
            cmd.rx_store = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            // checksum byte: close the frame, then drain or report
            cmd.set_idle = 1'b1;
            cmd.idx_clr  = 1'b1;
            state_nxt    = sts.csum_match ? S_FETCH : S_ERR_CSUM;
          end
        end else if (sts.action == ACT_RX_END && sts.phase == PH_RX) begin
          cmd.set_idle = 1'b1;
          state_nxt    = S_ERR_TIMEOUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HDR_SYNC: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_SYNC;
          state_nxt    = S_HDR_PID;
        end
      end
      S_HDR_PID: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_PID;
          state_nxt    = S_IDLE;
        end
      end
      S_TX_ECHO: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_DATA;
          state_nxt    = S_IDLE;
        end
      end
      S_TX_ECHO_LAST: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_DATA;
          state_nxt    = S_TX_CSUM;
        end
      end
      S_TX_CSUM: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_CSUM;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ERR_CSUM: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_ERR_CSUM;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ERR_TIMEOUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_ERR_TIMEOUT;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FETCH: begin
        // buffer read address settles here, data is registered for S_DRAIN
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_RX_BYTE;
          cmd.out_last = sts.idx_last;
          cmd.idx_inc  = 1'b1;
          state_nxt    = sts.idx_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.load_out == 1'b0) && (cmd.upd_start == 1'b0))
    else $error("item accepted while a result is being produced");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.upd_start, cmd.upd_tx, cmd.rx_store, cmd.set_idle}))
    else $error("conflicting frame state updates");

  a_latch_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == S_DECODE)
    else $error("latched item not decoded");
`endif

endmodule

[design/lin_frame_builder_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame builder/checker
// Master-side LIN frame engine: header bytes, transmit checksum, receive
// buffering and checksum check.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item is latched in the cycle it is accepted
// and decoded in the next, then each result word it causes is loaded into the
// output register from a state of its own, which waits until that register is
// free. Releasing a frame that passed its checksum reads every buffered byte
// from the receive buffer RAM through its registered read port, fetching each
// byte in S_FETCH before loading it in S_DRAIN. Ready comes back as soon as the
// last result word sits in the output register, so the next item is taken
// while that word waits on the result channel.
module lin_frame_builder_checker_top #(
  parameter int unsigned MAX_PAYLOAD = lfbc_pkg::DEF_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst_n,
  lfbc_in_if.sink    in_ch,
  lfbc_out_if.source out_ch
);
  import lfbc_pkg::*;

  lfbc_cmd_t cmd;
  lfbc_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  lfbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfbc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_frame_number   (in_ch.frame_number),
    .in_enhanced_mode  (in_ch.enhanced_mode),
    .in_payload_length (in_ch.payload_length),
    .in_data_value     (in_ch.data_value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.out_kind),
    .out_byte_value    (out_ch.byte_value),
    .out_status        (out_ch.status),
    .out_last_flag     (out_ch.last_flag)
  );

endmodule
